FILE: rtl/core/i2cbb_pkg.sv
// Shared types and constants for the bit-level I2C master core.
// Used by the sequencer, the register port and the top level.
package i2cbb_pkg;

    localparam int TicksWidth = 16;
    localparam int AddrWidth  = 3;

    localparam logic [AddrWidth-1:0] REG_TICKS_PER_US_ADDR = 3'd0;

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ      = 3'd3,
        CMD_WAIT_ACK  = 3'd4,
        CMD_SEND_ACK  = 3'd5,
        CMD_SEND_NACK = 3'd6
    } cmd_t;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [2:0] command;
        logic [7:0] write_byte;
        logic       ack_after_read;
        logic       sda_level;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_released;
        logic       sda_is_input;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
        logic       rejected;
    } result_t;

endpackage

FILE: rtl/core/i2cbb_apb.sv
// Configuration register port: holds ticks_per_microsecond.
// Depends on i2cbb_pkg.
module i2cbb_apb (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cbb_pkg::AddrWidth-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [i2cbb_pkg::TicksWidth-1:0] ticks_per_us
);
    import i2cbb_pkg::*;

    logic [TicksWidth-1:0] ticks_reg;
    logic                  sel_ticks;

    assign pready       = 1'b1;
    assign sel_ticks    = (paddr == REG_TICKS_PER_US_ADDR);
    assign ticks_per_us = ticks_reg;
    assign prdata       = sel_ticks ? {{(32-TicksWidth){1'b0}}, ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TicksWidth'(1);
        end
        else if (psel && penable && pwrite && pready && sel_ticks)
        begin
            ticks_reg <= pwdata[TicksWidth-1:0];
        end
    end

endmodule

FILE: rtl/core/i2cbb_seq.sv
// Bus sequencer: prescaler, phase timer, bit counter, shift register and pins.
// Computes one item's result from the held state. Depends on i2cbb_pkg.
module i2cbb_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  i2cbb_pkg::item_t                 item,
    input  logic [i2cbb_pkg::TicksWidth-1:0] ticks_per_us,
    output i2cbb_pkg::result_t               result
);
    import i2cbb_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START_A  = 5'd1,
        PH_START_B  = 5'd2,
        PH_STOP_A   = 5'd3,
        PH_STOP_B   = 5'd4,
        PH_WACK_A   = 5'd5,
        PH_WACK_B   = 5'd6,
        PH_ACK_A    = 5'd7,
        PH_ACK_B    = 5'd8,
        PH_WR_PRE   = 5'd9,
        PH_WR_SETUP = 5'd10,
        PH_WR_HIGH  = 5'd11,
        PH_WR_LOW   = 5'd12,
        PH_WR_TAIL  = 5'd13,
        PH_RD_LOW   = 5'd14,
        PH_RD_HIGH  = 5'd15
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [4:0]            timer_reg, timer_next, timer_dec;
    logic [TicksWidth-1:0] prescale_reg, prescale_next, limit;
    logic [TicksWidth:0]   prescale_inc;
    logic [3:0]            bit_count_reg, bit_count_next, bit_inc;
    logic [7:0]            shift_reg, shift_next, shift_sh;
    logic [7:0]            last_read_reg, last_read_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  dir_in_reg, dir_in_next;
    logic                  busy_reg, busy_next;
    logic                  ack_after_reg, ack_after_next;
    logic                  nack_reg, nack_next;
    logic                  done, rej;

    assign limit        = (ticks_per_us == '0) ? TicksWidth'(1) : ticks_per_us;
    assign prescale_inc = {1'b0, prescale_reg} + (TicksWidth+1)'(1);
    assign timer_dec    = (timer_reg != 5'd0) ? timer_reg - 5'd1 : 5'd0;
    assign bit_inc      = bit_count_reg + 4'd1;
    assign shift_sh     = {shift_reg[6:0], 1'b0};

    always_comb
    begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        prescale_next  = prescale_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        last_read_next = last_read_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        dir_in_next    = dir_in_reg;
        busy_next      = busy_reg;
        ack_after_next = ack_after_reg;
        nack_next      = nack_reg;
        done           = 1'b0;
        rej            = 1'b0;

        if (item.kind == KIND_COMMAND)
        begin
            if (busy_reg)
            begin
                rej = 1'b1;
            end
            else if (item.command <= CMD_SEND_NACK)
            begin
                busy_next      = 1'b1;
                prescale_next  = '0;
                bit_count_next = 4'd0;
                unique case (item.command)
                    CMD_START:
                    begin
                        dir_in_next = 1'b0;
                        scl_next    = 1'b1;
                        sda_next    = 1'b1;
                        phase_next  = PH_START_A;
                        timer_next  = 5'd4;
                    end
                    CMD_STOP:
                    begin
                        dir_in_next = 1'b0;
                        scl_next    = 1'b0;
                        sda_next    = 1'b0;
                        phase_next  = PH_STOP_A;
                        timer_next  = 5'd4;
                    end
                    CMD_WRITE:
                    begin
                        shift_next  = item.write_byte;
                        dir_in_next = 1'b0;
                        scl_next    = 1'b0;
                        phase_next  = PH_WR_PRE;
                        timer_next  = 5'd2;
                    end
                    CMD_READ:
                    begin
                        ack_after_next = item.ack_after_read;
                        last_read_next = 8'd0;
                        dir_in_next    = 1'b1;
                        sda_next       = 1'b1;
                        scl_next       = 1'b0;
                        phase_next     = PH_RD_LOW;
                        timer_next     = 5'd2;
                    end
                    CMD_WAIT_ACK:
                    begin
                        dir_in_next = 1'b1;
                        sda_next    = 1'b1;
                        phase_next  = PH_WACK_A;
                        timer_next  = 5'd10;
                    end
                    default:
                    begin
                        scl_next    = 1'b0;
                        dir_in_next = 1'b0;
                        sda_next    = (item.command == CMD_SEND_ACK) ? 1'b0 : 1'b1;
                        phase_next  = PH_ACK_A;
                        timer_next  = 5'd2;
                    end
                endcase
            end
        end
        else if (busy_reg)
        begin
            if (prescale_inc >= {1'b0, limit})
            begin
                prescale_next = '0;
                timer_next    = timer_dec;
                if (timer_dec == 5'd0)
                begin
                    unique case (phase_reg)
                        PH_START_A:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_START_B;
                            timer_next = 5'd4;
                        end
                        PH_STOP_A:
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_STOP_B;
                            timer_next = 5'd4;
                        end
                        PH_WACK_A:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_WACK_B;
                            timer_next = 5'd10;
                        end
                        PH_ACK_A:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_ACK_B;
                            timer_next = 5'd2;
                        end
                        PH_WR_PRE:
                        begin
                            sda_next   = shift_reg[7];
                            phase_next = PH_WR_SETUP;
                            timer_next = 5'd2;
                        end
                        PH_WR_SETUP:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_WR_HIGH;
                            timer_next = 5'd4;
                        end
                        PH_WR_HIGH:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_WR_LOW;
                            timer_next = 5'd2;
                        end
                        PH_WR_LOW:
                        begin
                            bit_count_next = bit_inc;
                            shift_next     = shift_sh;
                            timer_next     = 5'd2;
                            if (bit_inc < 4'd8)
                            begin
                                sda_next   = shift_sh[7];
                                phase_next = PH_WR_SETUP;
                            end
                            else
                            begin
                                phase_next = PH_WR_TAIL;
                            end
                        end
                        PH_RD_LOW:
                        begin
                            scl_next       = 1'b1;
                            last_read_next = {last_read_reg[6:0], item.sda_level};
                            phase_next     = PH_RD_HIGH;
                            timer_next     = 5'd2;
                        end
                        PH_RD_HIGH:
                        begin
                            bit_count_next = bit_inc;
                            scl_next       = 1'b0;
                            timer_next     = 5'd2;
                            if (bit_inc < 4'd8)
                            begin
                                phase_next = PH_RD_LOW;
                            end
                            else
                            begin
                                dir_in_next = 1'b0;
                                sda_next    = ~ack_after_reg;
                                phase_next  = PH_ACK_A;
                            end
                        end
                        default:
                        begin
                            if (phase_reg == PH_WACK_B)
                            begin
                                nack_next = item.sda_level;
                            end
                            if (phase_reg == PH_START_B || phase_reg == PH_WACK_B
                                || phase_reg == PH_ACK_B)
                            begin
                                scl_next = 1'b0;
                            end
                            phase_next = PH_IDLE;
                            timer_next = 5'd0;
                            busy_next  = 1'b0;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
            else
            begin
                prescale_next = prescale_inc[TicksWidth-1:0];
            end
        end
    end

    assign result = '{
        scl_level:    scl_next,
        sda_released: sda_next,
        sda_is_input: dir_in_next,
        busy_res:     busy_next,
        done_res:     done,
        read_data:    last_read_next,
        ack_missing:  nack_next,
        rejected:     rej
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= 5'd0;
            prescale_reg  <= '0;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            last_read_reg <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            dir_in_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            ack_after_reg <= 1'b0;
            nack_reg      <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            prescale_reg  <= prescale_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            last_read_reg <= last_read_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            dir_in_reg    <= dir_in_next;
            busy_reg      <= busy_next;
            ack_after_reg <= ack_after_next;
            nack_reg      <= nack_next;
        end
    end

endmodule

FILE: rtl/core/i2c_bitbang_master_core.sv
// Top level of the bit-level I2C master: input register, sequencer, result register.
// Depends on i2cbb_pkg, i2cbb_apb and i2cbb_seq.
//
// Takes one command or tick beat per clock while res_stall does not hold the output, and
// returns one result beat for each: the beat is held in an input register, the sequencer
// makes one step from it combinationally, and the result register holds the outcome until
// it is taken. Bus timing is counted in tick beats:
// ticks_per_microsecond ticks make one microsecond (zero counts as one), and every phase
// lasts its fixed number of microseconds. Commands that arrive while a sequence runs
// come back with rejected set.
module i2c_bitbang_master_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  i2cbb_pkg::item_t                item,
    output logic                            res_valid,
    input  logic                            res_stall,
    output i2cbb_pkg::result_t              res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cbb_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import i2cbb_pkg::*;

    logic [TicksWidth-1:0] ticks_per_us;
    logic                  in_valid_reg;
    item_t                 in_reg;
    logic                  res_valid_reg;
    result_t               res_reg;
    result_t               step_result;
    logic                  out_load;
    logic                  fire;

    assign out_load   = !res_valid_reg || !res_stall;
    assign fire       = in_valid_reg && out_load;
    assign item_stall = in_valid_reg && !out_load;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    i2cbb_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .ticks_per_us (ticks_per_us)
    );

    i2cbb_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (in_reg),
        .ticks_per_us (ticks_per_us),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= step_result;
        end
    end

endmodule

FILE: rtl/core/i2cbb_checker.sv
// Port-level checks for the bit-level I2C master, bound to the top level.
// Depends on i2cbb_pkg and i2c_bitbang_master_core.
module i2cbb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_stall,
    input i2cbb_pkg::result_t res
);
    import i2cbb_pkg::*;

    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> !res.busy_res)
        else $error("done beat still shows busy");

    a_reject_busy : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.rejected |-> res.busy_res && !res.done_res)
        else $error("rejected beat outside a running sequence");

    a_input_released : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.sda_is_input |-> res.sda_released)
        else $error("SDA sampled while pulled low");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result beat changed");

endmodule

bind i2c_bitbang_master_core i2cbb_checker u_i2cbb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
